>>> rtl/bra_pkg.sv
// bitmap run allocator: shared widths, codes and types
// no dependencies; imported by the interfaces and every rtl module but bra_ram

package bra_pkg;

   localparam int WORD_W       = 32;    // bits per bitmap word
   localparam int BIT_W        = 5;     // bit offset inside a word
   localparam int CMD_W        = 2;
   localparam int START_W      = 10;
   localparam int CNT_W        = 11;
   localparam int LEN_W        = 11;    // bit_length and any bit position in use
   localparam int STAT_W       = 2;
   localparam int WIDX_W       = LEN_W - BIT_W;   // word index of a position in use
   localparam int LEN_WORDS    = 2 ** WIDX_W;     // words a position in use can reach
   localparam int LEN_MAX      = 2 ** LEN_W - 1;
   localparam int LEN_RESET    = 1024;
   localparam int MAX_BITS_DEF = 1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_OVERRUN   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FILL,
      S_SEARCH,
      S_DONE
   } state_type;

   // per-command context handed to the word unit
   typedef struct packed {
      logic [WIDX_W-1:0] first_idx;
      logic [BIT_W-1:0]  lo_bit;
      logic [WIDX_W-1:0] last_idx;
      logic [BIT_W-1:0]  hi_bit;
      logic              fill_value;
      logic [CNT_W-1:0]  count;
      logic [CNT_W-1:0]  run;
   } word_ctl_type;

   // search outcome for one word
   typedef struct packed {
      logic             found;
      logic [LEN_W-1:0] found_start;
      logic [CNT_W-1:0] run_out;
   } word_res_type;

endpackage

>>> rtl/bra_if.sv
// bitmap run allocator: request and response channel interfaces
// depends on bra_pkg for the payload widths

interface bra_req_if import bra_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [START_W-1:0] start_bit;
   logic [CNT_W-1:0]   bit_count;
   logic               fill_value;

   modport source (output valid, cmd, start_bit, bit_count, fill_value, input ready);
   modport sink   (input valid, cmd, start_bit, bit_count, fill_value, output ready);
endinterface

interface bra_rsp_if import bra_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [START_W-1:0] run_start;

   modport source (output valid, status, run_start, input ready);
   modport sink   (input valid, status, run_start, output ready);
endinterface

>>> rtl/bra_ram.sv
// bitmap run allocator: generic single write, single read ram
// registered read data; no package dependency

module bra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bra_word_unit.sv
// bitmap run allocator: shared per-word unit for fill merge and run search
// depends on bra_pkg for word_ctl_type and word_res_type

module bra_word_unit import bra_pkg::*; (
   input  logic [WORD_W-1:0] word,
   input  logic [WIDX_W-1:0] word_idx,
   input  word_ctl_type      ctl,
   output logic [WORD_W-1:0] fill_word,
   output word_res_type      res
);

   // index of lowest set bit, 32 if none
   function automatic logic [BIT_W:0] trail_zeros(input logic [WORD_W-1:0] w);
      logic [BIT_W:0] n;
      n = (BIT_W + 1)'(WORD_W);
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) n = (BIT_W + 1)'(i);
      end
      return n;
   endfunction

   // free bits above the highest set bit, 32 if none
   function automatic logic [BIT_W:0] lead_zeros(input logic [WORD_W-1:0] w);
      logic [BIT_W:0] n;
      n = (BIT_W + 1)'(WORD_W);
      for (int i = 0; i < WORD_W; i++) begin
         if (w[i]) n = (BIT_W + 1)'(WORD_W - 1 - i);
      end
      return n;
   endfunction

   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] n;
      n = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) n = BIT_W'(i);
      end
      return n;
   endfunction

   // bit i set when the window of c bits from i holds a used bit or leaves the word;
   // built from doubling windows, padded with used bits above the word
   function automatic logic [WORD_W-1:0] window_used(input logic [WORD_W-1:0] w,
                                                     input logic [BIT_W:0]    c);
      logic [2*WORD_W-1:0] win;
      logic [2*WORD_W-1:0] acc;
      logic [2*WORD_W-1:0] pad;
      win = {{WORD_W{1'b1}}, w};
      acc = '0;
      for (int b = 0; b <= BIT_W; b++) begin
         pad = ~({(2*WORD_W){1'b1}} >> (1 << b));
         if (c[b]) acc = win | (acc >> (1 << b)) | pad;
         win = win | (win >> (1 << b)) | pad;
      end
      return acc[WORD_W-1:0];
   endfunction

   logic [WORD_W-1:0] lo_mask;
   logic [WORD_W-1:0] hi_mask;
   logic [WORD_W-1:0] range_mask;
   logic [WORD_W-1:0] used;
   logic [WORD_W-1:0] win_used;
   logic [BIT_W:0]    tz;
   logic [BIT_W:0]    lz;
   logic [CNT_W:0]    cross_len;
   logic              cross_hit;
   logic              inside_hit;
   logic [LEN_W-1:0]  base;

   always_comb begin
      lo_mask    = (word_idx == ctl.first_idx) ? ({WORD_W{1'b1}} << ctl.lo_bit) : '1;
      hi_mask    = (word_idx == ctl.last_idx) ? ({WORD_W{1'b1}} >> ~ctl.hi_bit) : '1;
      range_mask = lo_mask & hi_mask;
      fill_word  = ctl.fill_value ? (word | range_mask) : (word & ~range_mask);

      // outside the range counts as used
      used       = word | ~range_mask;
      tz         = trail_zeros(used);
      lz         = lead_zeros(used);
      win_used   = window_used(used, ctl.count[BIT_W:0]);
      base       = {word_idx, {BIT_W{1'b0}}};

      // run carried in from earlier words plus the free bits at the bottom
      cross_len  = {1'b0, ctl.run} + (CNT_W + 1)'(tz);
      cross_hit  = (ctl.count != '0) && (cross_len >= {1'b0, ctl.count});
      inside_hit = (ctl.count != '0) && (ctl.count <= CNT_W'(WORD_W)) && (~win_used != '0);

      res.found = cross_hit || inside_hit;
      if (cross_hit) begin
         res.found_start = base - ctl.run;
      end else begin
         res.found_start = base + LEN_W'(first_zero(win_used));
      end
      if (used == '0) begin
         res.run_out = ctl.run + CNT_W'(WORD_W);
      end else begin
         res.run_out = CNT_W'(lz);
      end
   end

endmodule

>>> rtl/bitmap_run_allocator_core.sv
// bitmap run allocator: top level with sequencer, bitmap ram and response register
// depends on bra_pkg, bra_if, bra_ram and bra_word_unit
//
// An allocation bitmap (set bit = used) kept as 32-bit words in a ram and empty
// after reset. One request carries one command and gives exactly one response
// transfer. Clear empties the whole map by dropping the per-word valid flags;
// a word without its flag reads as all free. Fill walks the words from
// start_bit to the end of the range, one read-modify-write per cycle, and
// reports overrun when bit_count is zero or the range passes the bits in use.
// Search walks the words from start_bit to the end of the bits in use, one word
// per cycle, and returns the lowest start of the first run of bit_count free
// bits. The bits in use are csr bit_length limited to MAX_BITS. Clear, an
// unused command code, and fills or searches that touch no word go straight
// to the done state and from there to the response register; a fill or search
// is paced by the single ram read port feeding the shared word unit one word
// per cycle. The block takes no request while a command is in progress; a
// finished response waits in its own register, so the next request may be
// taken before it has been collected. bit_length may only be written while no
// command is in progress. Only the words that a position below 2048 can
// reach are stored.

module bitmap_run_allocator_core import bra_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   bra_req_if.sink          req_chan,
   bra_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata
);

   localparam int NUM_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
   localparam int MEM_WORDS = (NUM_WORDS < LEN_WORDS) ? NUM_WORDS : LEN_WORDS;
   localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int CAP       = (MAX_BITS < LEN_MAX) ? MAX_BITS : LEN_MAX;

   // control
   state_type             state_ff, state_in;
   logic                  issue_ff, issue_in;
   logic                  data_vld_ff, data_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]      bit_length_ff, bit_length_in;
   logic [MEM_WORDS-1:0]  valid_ff, valid_in;

   // command context and walk pointers
   logic [WIDX_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [WIDX_W-1:0]     data_idx_ff, data_idx_in;
   logic [WIDX_W-1:0]     first_ff, first_in;
   logic [BIT_W-1:0]      lo_bit_ff, lo_bit_in;
   logic [LEN_W-1:0]      lim_m1_ff, lim_m1_in;
   logic                  fill_ff, fill_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      run_ff, run_in;
   logic [STAT_W-1:0]     res_status_ff, res_status_in;
   logic [START_W-1:0]    res_start_ff, res_start_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]    rsp_start_ff, rsp_start_in;

   // request decode
   logic                  req_xfer;
   logic [LEN_W-1:0]      len_used;
   logic [LEN_W:0]        fill_sum;
   logic                  fill_over;
   logic [LEN_W-1:0]      fill_end;
   logic                  fill_go;
   logic                  search_go;

   // walk datapath
   logic                  walking;
   logic                  last_data;
   logic                  rsp_free;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [WORD_W-1:0]     ram_rd_data;
   logic [WORD_W-1:0]     word_q;
   logic [WORD_W-1:0]     fill_word;
   word_ctl_type          word_ctl;
   word_res_type          word_res;

   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign walking   = (state_ff == S_FILL) || (state_ff == S_SEARCH);
   assign last_data = data_vld_ff && (data_idx_ff == lim_m1_ff[LEN_W-1:BIT_W]);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   // length in use and fill range, from the request payload
   always_comb begin
      len_used  = (bit_length_ff > LEN_W'(CAP)) ? LEN_W'(CAP) : bit_length_ff;
      fill_sum  = (LEN_W + 1)'(req_chan.start_bit) + (LEN_W + 1)'(req_chan.bit_count);
      fill_over = (req_chan.bit_count == '0) || (fill_sum > {1'b0, len_used});
      fill_end  = fill_over ? len_used : fill_sum[LEN_W-1:0];
      fill_go   = LEN_W'(req_chan.start_bit) < fill_end;
      search_go = (req_chan.bit_count != '0) && (LEN_W'(req_chan.start_bit) < len_used);
   end

   // bitmap words; a word never written since clear reads through as free
   bra_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (data_idx_ff[AW-1:0]),
      .wr_data (fill_word),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign word_q = valid_ff[data_idx_ff[AW-1:0]] ? ram_rd_data : '0;

   always_comb begin
      word_ctl.first_idx  = first_ff;
      word_ctl.lo_bit     = lo_bit_ff;
      word_ctl.last_idx   = lim_m1_ff[LEN_W-1:BIT_W];
      word_ctl.hi_bit     = lim_m1_ff[BIT_W-1:0];
      word_ctl.fill_value = fill_ff;
      word_ctl.count      = count_ff;
      word_ctl.run        = run_ff;
   end

   bra_word_unit u_word (
      .word      (word_q),
      .word_idx  (data_idx_ff),
      .ctl       (word_ctl),
      .fill_word (fill_word),
      .res       (word_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               priority if (req_chan.cmd == CMD_FILL && fill_go) begin
                  state_in = S_FILL;
               end else if (req_chan.cmd == CMD_SEARCH && search_go) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FILL: begin
            if (last_data) state_in = S_DONE;
         end
         S_SEARCH: begin
            if (data_vld_ff && (word_res.found || last_data)) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_chan.ready = (state_ff == S_IDLE);
      ram_rd_en      = walking && issue_ff;
      ram_wr_en      = (state_ff == S_FILL) && data_vld_ff;

      bit_length_in  = csr_we ? csr_wdata : bit_length_ff;
      valid_in       = valid_ff;
      issue_in       = issue_ff;
      data_vld_in    = 1'b0;
      data_idx_in    = rd_addr_ff;
      rd_addr_in     = rd_addr_ff;
      first_in       = first_ff;
      lo_bit_in      = lo_bit_ff;
      lim_m1_in      = lim_m1_ff;
      fill_in        = fill_ff;
      count_in       = count_ff;
      run_in         = run_ff;
      res_status_in  = res_status_ff;
      res_start_in   = res_start_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_start_in   = rsp_start_ff;

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      // latch the command context
      if (req_xfer) begin
         first_in     = WIDX_W'(req_chan.start_bit[START_W-1:BIT_W]);
         lo_bit_in    = req_chan.start_bit[BIT_W-1:0];
         rd_addr_in   = WIDX_W'(req_chan.start_bit[START_W-1:BIT_W]);
         fill_in      = req_chan.fill_value;
         count_in     = req_chan.bit_count;
         run_in       = '0;
         res_start_in = '0;
         issue_in     = 1'b0;
         unique case (req_chan.cmd)
            CMD_CLEAR: begin
               valid_in      = '0;
               res_status_in = STAT_OK;
            end
            CMD_FILL: begin
               lim_m1_in     = fill_end - LEN_W'(1);
               issue_in      = fill_go;
               res_status_in = fill_over ? STAT_OVERRUN : STAT_OK;
            end
            CMD_SEARCH: begin
               lim_m1_in     = len_used - LEN_W'(1);
               issue_in      = search_go;
               res_status_in = STAT_NOT_FOUND;
            end
            default: begin
               res_status_in = STAT_OK;
            end
         endcase
      end

      // issue one ram read per cycle up to the last word of the range
      if (ram_rd_en) begin
         data_vld_in = 1'b1;
         if (rd_addr_ff == lim_m1_ff[LEN_W-1:BIT_W]) begin
            issue_in = 1'b0;
         end else begin
            rd_addr_in = rd_addr_ff + WIDX_W'(1);
         end
      end

      // fill write-back marks the word as holding real data
      if (ram_wr_en) valid_in[data_idx_ff[AW-1:0]] = 1'b1;

      // search: carry the run into the next word, stop at the first hit
      if (state_ff == S_SEARCH && data_vld_ff) begin
         run_in = word_res.run_out;
         if (word_res.found) begin
            res_status_in = STAT_OK;
            res_start_in  = word_res.found_start[START_W-1:0];
            issue_in      = 1'b0;
            data_vld_in   = 1'b0;
         end
      end

      // hand the result to the response register
      if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_start_in  = res_start_ff;
      end

      rsp_chan.valid     = rsp_valid_ff;
      rsp_chan.status    = rsp_status_ff;
      rsp_chan.run_start = rsp_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_ff      <= 1'b0;
         data_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bit_length_ff <= LEN_W'(LEN_RESET);
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         data_vld_ff   <= data_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         bit_length_ff <= bit_length_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      data_idx_ff   <= data_idx_in;
      first_ff      <= first_in;
      lo_bit_ff     <= lo_bit_in;
      lim_m1_ff     <= lim_m1_in;
      fill_ff       <= fill_in;
      count_ff      <= count_in;
      run_ff        <= run_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

endmodule

>>> sim/bra_alloc_checker.sv
`timescale 1ns / 100ps
// bitmap run allocator: checker that watches the request, response and csr ports,
// keeps its own copy of the bitmap and compares every response with the predicted one
// depends on bra_pkg and the channel interfaces in bra_if

module bra_alloc_checker import bra_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   bra_req_if               req_mon,
   bra_rsp_if               rsp_mon,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               runs_found
);

   localparam int NUM_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [START_W-1:0] run_start;
   } alloc_rsp_type;

   logic [WORD_W-1:0] map_words [NUM_WORDS];
   logic [LEN_W-1:0]  length_reg;
   alloc_rsp_type     rsp_expected_q [$];

   function automatic int bits_in_use();
      return (int'(length_reg) > MAX_BITS) ? MAX_BITS : int'(length_reg);
   endfunction

   function automatic logic [STAT_W-1:0] fill_range(int start, int count, logic v);
      int len;
      int stop;
      logic [STAT_W-1:0] st;
      len = bits_in_use();
      if (count == 0 || start + count > len) begin
         stop = len;
         st   = STAT_OVERRUN;
      end else begin
         stop = start + count;
         st   = STAT_OK;
      end
      for (int p = start; p < stop; p++)
         if (p < MAX_BITS) map_words[p / WORD_W][p % WORD_W] = v;
      return st;
   endfunction

   // lowest start of the first run of count free bits at or after start
   function automatic logic find_free_run(int start, int count, output int at);
      int len;
      int run;
      int p;
      int w;
      len = bits_in_use();
      run = 0;
      p   = start;
      at  = 0;
      while (p < len) begin
         w = p / WORD_W;
         if (map_words[w] == '1) begin
            run = 0;
            p   = (w + 1) * WORD_W;
         end else begin
            if (!map_words[w][p % WORD_W]) begin
               run++;
               if (run == count) begin
                  at = p + 1 - run;
                  return 1'b1;
               end
            end else begin
               run = 0;
            end
            p++;
         end
      end
      return 1'b0;
   endfunction

   function automatic alloc_rsp_type predict_rsp(logic [CMD_W-1:0] op, int start, int count,
                                                 logic v);
      alloc_rsp_type r;
      int at;
      r = '{status: STAT_OK, run_start: '0};
      case (op)
         CMD_CLEAR: begin
            foreach (map_words[i]) map_words[i] = '0;
         end
         CMD_FILL: begin
            r.status = fill_range(start, count, v);
         end
         CMD_SEARCH: begin
            if (find_free_run(start, count, at)) begin
               r.run_start = at[START_W-1:0];
            end else begin
               r.status = STAT_NOT_FOUND;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset) begin
         foreach (map_words[i]) map_words[i] = '0;
         length_reg = LEN_W'(LEN_RESET);
         rsp_expected_q.delete();
         fail_count = 0;
         runs_found = 0;
      end else begin
         // the response side first, so a transfer never meets a request of the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rsp_expected_q.size() == 0) begin
               $error("response with nothing outstanding: status %0d run_start %0d",
                      rsp_mon.status, rsp_mon.run_start);
               fail_count++;
            end else begin
               want = rsp_expected_q.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.run_start !== want.run_start) begin
                  $error("run_start mismatch: expected %0d, actual %0d",
                         want.run_start, rsp_mon.run_start);
                  fail_count++;
               end
               if (want.status == STAT_OK && rsp_mon.status === want.status &&
                   rsp_mon.run_start === want.run_start)
                  runs_found++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            rsp_expected_q.push_back(predict_rsp(req_mon.cmd, int'(req_mon.start_bit),
                                                 int'(req_mon.bit_count),
                                                 req_mon.fill_value));
         if (csr_we)
            length_reg = csr_wdata;
      end
      pending = rsp_expected_q.size();
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// bitmap run allocator: testbench top, makes clock, reset, requests, csr writes and
// response back-pressure; depends on bra_pkg, bra_if, the core and bra_alloc_checker

module tb_top import bra_pkg::*; ();

   localparam int               MAX_BITS      = 1024;
   localparam int               NUM_PHASES    = 8;
   localparam int               PHASE_ITEMS   = 110;
   localparam int               CYCLE_LIMIT   = 400000;
   localparam logic [CMD_W-1:0] CMD_RESERVED  = 2'd3;   // unused code, must do nothing

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [LEN_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int runs_found;

   // stimulus bookkeeping for the summary
   int n_fill;
   int n_search;
   int n_clear;
   int n_reserved;
   int n_settings;
   int cycle_count;

   // idling controls, percent of cycles
   int req_gap_pct;
   int rsp_stall_pct;

   bra_req_if req_if ();
   bra_rsp_if rsp_if ();

   bitmap_run_allocator_core #(.MAX_BITS(MAX_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   bra_alloc_checker #(.MAX_BITS(MAX_BITS)) chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .runs_found (runs_found)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog, generous against the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // one request transfer; valid stays high after the transfer until the next call
   // or release_req decides what happens at the following falling edge
   task automatic send_item(logic [CMD_W-1:0] op, int start, int count, logic v);
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= op;
      req_if.start_bit  <= start[START_W-1:0];
      req_if.bit_count  <= count[CNT_W-1:0];
      req_if.fill_value <= v;
      do @(posedge clock); while (!req_if.ready);
      case (op)
         CMD_CLEAR:  n_clear++;
         CMD_FILL:   n_fill++;
         CMD_SEARCH: n_search++;
         default:    n_reserved++;
      endcase
   endtask

   task automatic release_req();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // every command gives a response, so an empty queue means the core is idle;
   // a few spare cycles before touching the csr all the same
   task automatic drain();
      release_req();
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_length(int len);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= len[LEN_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      n_settings++;
   endtask

   // bit counts biased to short runs, with zero, exact-to-end and oversized counts mixed in
   function automatic int pick_count(int start, int len);
      int c;
      c = $urandom_range(99);
      if (c < 5) return 0;
      if (c < 10) return (start < len) ? len - start : $urandom_range(2047, 0);
      if (c < 15) return $urandom_range(2047, 0);
      if (c < 30) return $urandom_range(256, 33);
      return $urandom_range(48, 1);
   endfunction

   task automatic random_item(int len);
      int pick;
      int start;
      int count;
      logic v;
      pick  = $urandom_range(99);
      // mostly inside the bits in use, now and then anywhere in the field
      if (len > 0 && $urandom_range(99) < 85)
         start = $urandom_range(len - 1, 0);
      else
         start = $urandom_range(1023, 0);
      count = pick_count(start, len);
      v     = ($urandom_range(99) < 55);
      if (pick < 3)
         send_item(CMD_CLEAR, start, count, v);
      else if (pick < 5)
         send_item(CMD_RESERVED, start, count, v);
      else if (pick < 52)
         send_item(CMD_FILL, start, count, v);
      else begin
         // searches from the bottom are the usual allocator pattern
         if ($urandom_range(99) < 30) start = 0;
         send_item(CMD_SEARCH, start, count, v);
      end
   endtask

   // hand-picked commands on the full 1024-bit map
   task automatic directed_items();
      send_item(CMD_SEARCH,   0,    1,    1'b0);   // empty map, first bit
      send_item(CMD_FILL,     0,    1024, 1'b1);   // range ends exactly at the end
      send_item(CMD_SEARCH,   0,    1,    1'b0);   // every word full, nothing found
      send_item(CMD_FILL,     1023, 1,    1'b0);   // top bit freed
      send_item(CMD_SEARCH,   0,    1,    1'b0);   // full words skipped up to the last bit
      send_item(CMD_SEARCH,   0,    2,    1'b0);
      send_item(CMD_FILL,     1000, 0,    1'b0);   // zero count fills to the end, overrun
      send_item(CMD_SEARCH,   0,    24,   1'b0);
      send_item(CMD_SEARCH,   0,    25,   1'b0);
      send_item(CMD_FILL,     1020, 10,   1'b1);   // range passes the end
      send_item(CMD_SEARCH,   0,    0,    1'b0);   // zero count never matches
      send_item(CMD_RESERVED, 1023, 2047, 1'b1);   // unused code leaves the map alone
      send_item(CMD_SEARCH,   1000, 20,   1'b0);
      send_item(CMD_CLEAR,    1023, 2047, 1'b1);
      send_item(CMD_SEARCH,   1023, 1,    1'b0);
      send_item(CMD_SEARCH,   1023, 2,    1'b0);
      send_item(CMD_FILL,     5,    2047, 1'b1);   // oversized count
      send_item(CMD_FILL,     32,   32,   1'b0);   // one whole word freed
      send_item(CMD_SEARCH,   0,    5,    1'b0);
      send_item(CMD_SEARCH,   0,    6,    1'b0);   // bottom run too short, found at the freed word
      send_item(CMD_SEARCH,   3,    32,   1'b0);
      send_item(CMD_SEARCH,   0,    1024, 1'b0);
      send_item(CMD_CLEAR,    0,    0,    1'b0);
      send_item(CMD_SEARCH,   0,    1024, 1'b0);   // whole empty map is one run
   endtask

   initial begin
      int lens [NUM_PHASES];
      int mode;
      lens = '{1024, 1, 1024, 0, 32, 33, 1000, 1024};
      lens[3] = $urandom_range(1023, 2);

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.cmd        = CMD_CLEAR;
      req_if.start_bit  = '0;
      req_if.bit_count  = '0;
      req_if.fill_value = 1'b0;
      rsp_if.ready      = 1'b0;
      req_gap_pct       = 0;
      rsp_stall_pct     = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset value written explicitly, then the directed part with no idling
      write_length(1024);
      directed_items();
      drain();

      // random phases: each a bit_length setting paired with one idling pattern
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_length(lens[ph]);
         mode = ph % 4;
         case (mode)
            0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_gap_pct = 53; rsp_stall_pct = 0;  end
            2: begin req_gap_pct = 0;  rsp_stall_pct = 53; end
            default: begin req_gap_pct = 25; rsp_stall_pct = 25; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_item(lens[ph]);
         drain();
      end

      // tail: let any stray response show up
      rsp_stall_pct = 0;
      repeat (40) @(posedge clock);

      $display("covered %0d fills, %0d searches, %0d clears, %0d unused codes, %0d lengths",
               n_fill, n_search, n_clear, n_reserved, n_settings);
      $display("%0d responses matched with ok status, %0d check failures",
               runs_found, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
